@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by vfa_ctrl.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define VFA_ASSERT_IMP(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define VFA_ASSERT_NXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/vfa_pkg.sv @@
// ---------------------------------------------------------------------------
// vfa_pkg
// Shared widths, operation codes and controller/datapath command types.
// ---------------------------------------------------------------------------
package vfa_pkg;

   localparam int MODE_W = 3;
   localparam int WORD_W = 64;
   localparam int EXP_W  = 11;   // signed working exponent

   localparam logic [MODE_W-1:0] MODE_ADD = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SUB = 3'd1;
   localparam logic [MODE_W-1:0] MODE_MUL = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DIV = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CMP = 3'd4;

   localparam logic [WORD_W-1:0] RESV_WORD = 64'h8000;

   typedef enum logic [4:0] {
      OP_IDLE, OP_LOAD, OP_PRE, OP_ALIGN, OP_SUM, OP_CHKZ, OP_NORM, OP_FMUL,
      OP_MFIX, OP_M0, OP_M1, OP_M2, OP_M3, OP_M4, OP_TNEG, OP_DINIT, OP_DSTEP,
      OP_DFIN, OP_RND7, OP_PACK, OP_FINISH
   } vfa_op_type;

   typedef enum logic [1:0] {PAIR_AB, PAIR_LB7, PAIR_LT, PAIR_LA7} vfa_pair_type;

   typedef enum logic [1:0] {CLS_ADD, CLS_MUL, CLS_DIV, CLS_OTHER} vfa_class_type;

   typedef struct packed {
      vfa_op_type   op;
      vfa_pair_type pair;
      logic         fine;   // 29/3 scaling, else 22/10
      logic         to_t;   // multiply result goes to t, else l
   } vfa_cmd_type;

   typedef struct packed {
      logic          early;
      logic          far;
      logic          l_zero;
      logic          norm_done;
      vfa_class_type cls;
      logic          dbl;
   } vfa_stat_type;

endpackage

@@ rtl/vfa_if.sv @@
// ---------------------------------------------------------------------------
// vfa_req_if / vfa_rsp_if
// Valid/ready channels for instruction and result words.
// ---------------------------------------------------------------------------
interface vfa_req_if;
   logic                        valid;
   logic                        ready;
   logic [vfa_pkg::MODE_W-1:0]  mode;
   logic                        is_double;
   logic [vfa_pkg::WORD_W-1:0]  operand_a;
   logic [vfa_pkg::WORD_W-1:0]  operand_b;

   modport source (output valid, mode, is_double, operand_a, operand_b, input ready);
   modport sink   (input valid, mode, is_double, operand_a, operand_b, output ready);
endinterface

interface vfa_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [vfa_pkg::WORD_W-1:0]  result_value;
   logic                        result_written;
   logic                        flag_negative;
   logic                        flag_zero;

   modport source (output valid, result_value, result_written, flag_negative,
                   flag_zero, input ready);
   modport sink   (input valid, result_value, result_written, flag_negative,
                   flag_zero, output ready);
endinterface

@@ rtl/vfa_datapath.sv @@
// ---------------------------------------------------------------------------
// vfa_datapath
// Operand registers, shared 32x32 multiplier, restoring divider, shifter.
// ---------------------------------------------------------------------------
module vfa_datapath (
   input  logic                        clock,
   input  logic [vfa_pkg::MODE_W-1:0]  in_mode,
   input  logic                        in_dbl,
   input  logic [vfa_pkg::WORD_W-1:0]  in_a,
   input  logic [vfa_pkg::WORD_W-1:0]  in_b,
   input  vfa_pkg::vfa_cmd_type        cmd,
   output vfa_pkg::vfa_stat_type       stat,
   output logic [vfa_pkg::WORD_W-1:0]  out_value,
   output logic                        out_written,
   output logic                        out_neg,
   output logic                        out_zero
);
   import vfa_pkg::*;

   function automatic logic f_zero(input logic [63:0] x);
      return x[15:7] == 9'd0;
   endfunction

   function automatic logic f_resv(input logic [63:0] x);
      return x[15:7] == 9'h100;
   endfunction

   function automatic logic [55:0] f_mant_d(input logic [63:0] x);
      return {1'b1, x[6:0], x[31:16], x[47:32], x[63:48]};
   endfunction

   function automatic logic [55:0] f_mant(input logic d, input logic [63:0] x);
      return d ? f_mant_d(x) : {32'd0, 1'b1, x[6:0], x[31:16]};
   endfunction

   function automatic logic f_mag_lt(input logic [63:0] x, input logic [63:0] y);
      return (x[14:7] < y[14:7]) ||
             ((x[14:7] == y[14:7]) && (f_mant_d(x) < f_mant_d(y)));
   endfunction

   // registers
   logic [63:0]             a_ff, a_in, b_ff, b_in;
   logic [MODE_W-1:0]       mode_ff, mode_in;
   logic                    dbl_ff, dbl_in;
   logic [55:0]             ma_ff, ma_in, mb_ff, mb_in;
   logic [63:0]             l_ff, l_in, t_ff, t_in, s_ff, s_in;
   logic signed [EXP_W-1:0] e_ff, e_in;
   logic                    neg_ff, neg_in;
   logic [63:0]             res_ff, res_in;
   logic                    cmp_n_ff, cmp_n_in, cmp_z_ff, cmp_z_in;
   logic [27:0]             rem_ff, rem_in, dsr_ff, dsr_in;
   logic [63:0]             ov_ff, ov_in;
   logic                    ow_ff, ow_in, on_ff, on_in, oz_ff, oz_in;

   // combinational
   vfa_class_type           cls;
   logic [63:0]             bflip, big, lil;
   logic                    swap, pre_early;
   logic [63:0]             pre_res;
   logic signed [EXP_W-1:0] mul_e, div_e;
   logic                    c_lt, c_eq, m_lt, m_eq;
   logic [7:0]              dexp;
   logic                    far;
   logic [63:0]             xop, yop;
   logic [31:0]             mx, my;
   logic [63:0]             prod, s_rnd, s_sh, p_sh, sp1, l_rnd;
   logic                    hi_nz, top_bit;
   logic [28:0]             r_sh;
   logic                    r_ge;
   logic [63:0]             pk;
   logic                    arith;

   always_comb begin
      case (mode_ff)
         MODE_ADD, MODE_SUB: cls = CLS_ADD;
         MODE_MUL:           cls = CLS_MUL;
         MODE_DIV:           cls = CLS_DIV;
         default:            cls = CLS_OTHER;
      endcase
   end

   assign bflip = (mode_ff == MODE_SUB) ? (b_ff ^ RESV_WORD) : b_ff;
   assign swap  = f_mag_lt(a_ff, bflip);
   assign big   = swap ? bflip : a_ff;
   assign lil   = swap ? a_ff : bflip;
   assign mul_e = $signed({3'd0, a_ff[14:7]}) + $signed({3'd0, b_ff[14:7]})
                  - $signed(11'd129);
   assign div_e = $signed({3'd0, a_ff[14:7]}) - $signed({3'd0, b_ff[14:7]})
                  + $signed(11'd129);

   // signed order of b against a
   assign m_lt = f_mag_lt(b_ff, a_ff);
   assign m_eq = (b_ff[14:7] == a_ff[14:7]) && (f_mant_d(b_ff) == f_mant_d(a_ff));
   always_comb begin
      c_lt = 1'b0;
      c_eq = 1'b0;
      if (f_zero(b_ff)) begin
         c_eq = f_zero(a_ff);
         c_lt = !f_zero(a_ff) && !a_ff[15];
      end else if (f_zero(a_ff)) begin
         c_lt = b_ff[15];
      end else if (b_ff[15] != a_ff[15]) begin
         c_lt = b_ff[15];
      end else begin
         c_eq = m_eq;
         c_lt = b_ff[15] ? (!m_lt && !m_eq) : m_lt;
      end
   end

   // early outcomes
   always_comb begin
      pre_early = 1'b1;
      pre_res   = 64'd0;
      case (cls)
         CLS_ADD: begin
            if (f_resv(a_ff) || f_resv(b_ff)) pre_res = RESV_WORD;
            else if (f_zero(b_ff))            pre_res = a_ff;
            else if (f_zero(a_ff))            pre_res = bflip;
            else                              pre_early = 1'b0;
         end
         CLS_MUL: begin
            pre_early = f_zero(a_ff) || f_zero(b_ff) || (mul_e <= 0);
         end
         CLS_DIV: begin
            if (f_zero(a_ff))      pre_res = 64'd0;
            else if (f_zero(b_ff)) pre_res = RESV_WORD;
            else                   pre_early = 1'b0;
         end
         default: pre_early = 1'b1;
      endcase
   end

   assign dexp = a_ff[14:7] - b_ff[14:7];
   assign far  = dbl_ff ? (dexp >= 8'd56) : (dexp >= 8'd24);

   // shared multiplier
   always_comb begin
      case (cmd.pair)
         PAIR_AB:  begin xop = {8'd0, ma_ff}; yop = {8'd0, mb_ff}; end
         PAIR_LB7: begin xop = l_ff; yop = {1'b0, mb_ff, 7'd0}; end
         PAIR_LT:  begin xop = l_ff; yop = t_ff; end
         default:  begin xop = l_ff; yop = {1'b0, ma_ff, 7'd0}; end
      endcase
      case (cmd.op)
         OP_M0:   begin mx = xop[31:0];  my = yop[31:0];  end
         OP_M1:   begin mx = xop[63:32]; my = yop[31:0];  end
         OP_M2:   begin mx = xop[31:0];  my = yop[63:32]; end
         OP_M3:   begin mx = xop[63:32]; my = yop[63:32]; end
         default: begin mx = ma_ff[31:0]; my = mb_ff[31:0]; end
      endcase
   end
   assign prod  = {32'd0, mx} * {32'd0, my};
   assign s_rnd = s_ff + (cmd.fine ? (64'd1 << 28) : (64'd1 << 21));
   assign s_sh  = cmd.fine ? (s_rnd >> 29) : (s_rnd >> 22);
   assign p_sh  = cmd.fine ? (prod << 3) : (prod << 10);
   assign sp1   = s_ff + 64'd1;
   assign l_rnd = l_ff + 64'd64;

   // normalization
   assign hi_nz   = dbl_ff ? (l_ff[63:56] != 8'd0) : (l_ff[63:24] != 40'd0);
   assign top_bit = dbl_ff ? l_ff[55] : l_ff[23];

   // divider
   assign r_sh = {rem_ff, l_ff[63]};
   assign r_ge = r_sh >= {1'b0, dsr_ff};

   // packing
   always_comb begin
      if (e_ff <= 0) begin
         pk = 64'd0;
      end else if (e_ff >= 256) begin
         pk = RESV_WORD;
      end else if (dbl_ff) begin
         pk = {l_ff[15:0], l_ff[31:16], l_ff[47:32], neg_ff, e_ff[7:0], l_ff[54:48]};
      end else begin
         pk = {32'd0, l_ff[15:0], neg_ff, e_ff[7:0], l_ff[22:16]};
      end
   end

   assign arith = (cls != CLS_OTHER);

   always_comb begin
      a_in = a_ff;  b_in = b_ff;  mode_in = mode_ff;  dbl_in = dbl_ff;
      ma_in = ma_ff;  mb_in = mb_ff;  l_in = l_ff;  t_in = t_ff;  s_in = s_ff;
      e_in = e_ff;  neg_in = neg_ff;  res_in = res_ff;
      cmp_n_in = cmp_n_ff;  cmp_z_in = cmp_z_ff;  rem_in = rem_ff;  dsr_in = dsr_ff;
      ov_in = ov_ff;  ow_in = ow_ff;  on_in = on_ff;  oz_in = oz_ff;
      case (cmd.op)
         OP_LOAD: begin
            mode_in = in_mode;
            dbl_in  = in_dbl;
            a_in    = in_dbl ? in_a : {32'd0, in_a[31:0]};
            b_in    = in_dbl ? in_b : {32'd0, in_b[31:0]};
         end
         OP_PRE: begin
            res_in   = pre_res;
            cmp_n_in = (mode_ff == MODE_CMP) && c_lt;
            cmp_z_in = (mode_ff == MODE_CMP) && c_eq;
            ma_in    = f_mant(dbl_ff, a_ff);
            mb_in    = f_mant(dbl_ff, b_ff);
            neg_in   = a_ff[15] ^ b_ff[15];
            e_in     = (cls == CLS_DIV) ? div_e : mul_e;
            if (cls == CLS_ADD) begin
               a_in   = big;
               b_in   = lil;
               neg_in = big[15];
               e_in   = $signed({3'd0, big[14:7]});
            end
         end
         OP_ALIGN: begin
            res_in = a_ff;
            l_in   = {8'd0, f_mant(dbl_ff, a_ff)};
            t_in   = {8'd0, f_mant(dbl_ff, b_ff)} >> dexp;
         end
         OP_SUM:  l_in = (a_ff[15] == b_ff[15]) ? (l_ff + t_ff) : (l_ff - t_ff);
         OP_CHKZ: res_in = 64'd0;
         OP_NORM: begin
            if (hi_nz) begin
               l_in = l_ff >> 1;
               e_in = e_ff + 11'sd1;
            end else if (!top_bit) begin
               l_in = l_ff << 1;
               e_in = e_ff - 11'sd1;
            end
         end
         OP_FMUL: l_in = (prod + (64'd1 << 22)) >> 23;
         OP_MFIX: begin
            if (dbl_ff ? l_ff[56] : l_ff[24]) begin
               l_in = l_ff >> 1;
               e_in = e_ff + 11'sd1;
            end
         end
         OP_M0: s_in = {32'd0, prod[63:32]};
         OP_M1, OP_M2: s_in = s_ff + prod;
         OP_M3: s_in = s_sh + p_sh;
         OP_M4: begin
            if (cmd.to_t) t_in = {1'b0, sp1[63:1]};
            else          l_in = {1'b0, sp1[63:1]};
         end
         OP_TNEG: t_in = 64'h8000_0000_0000_0000 - t_ff;
         OP_DINIT: begin
            rem_in = 28'd0;
            if (dbl_ff) begin
               l_in   = 64'h8000_0000_0000_0000;
               dsr_in = mb_ff[55:28];
            end else begin
               l_in   = {ma_ff[23:0], 40'd0};
               dsr_in = {4'd0, mb_ff[23:0]};
            end
         end
         OP_DSTEP: begin
            rem_in = r_ge ? 28'(r_sh - {1'b0, dsr_ff}) : r_sh[27:0];
            l_in   = {l_ff[62:0], r_ge};
         end
         OP_DFIN: l_in = dbl_ff ? (l_ff << 26) : (l_ff >> 17);
         OP_RND7: l_in = l_rnd >> 7;
         OP_PACK: res_in = pk;
         OP_FINISH: begin
            ov_in = arith ? (dbl_ff ? res_ff : {32'd0, res_ff[31:0]}) : 64'd0;
            ow_in = arith;
            on_in = arith ? res_ff[15] : cmp_n_ff;
            oz_in = arith ? (res_ff[15:7] == 9'd0) : cmp_z_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;  b_ff <= b_in;  mode_ff <= mode_in;  dbl_ff <= dbl_in;
      ma_ff <= ma_in;  mb_ff <= mb_in;  l_ff <= l_in;  t_ff <= t_in;  s_ff <= s_in;
      e_ff <= e_in;  neg_ff <= neg_in;  res_ff <= res_in;
      cmp_n_ff <= cmp_n_in;  cmp_z_ff <= cmp_z_in;  rem_ff <= rem_in;  dsr_ff <= dsr_in;
      ov_ff <= ov_in;  ow_ff <= ow_in;  on_ff <= on_in;  oz_ff <= oz_in;
   end

   assign stat.early     = pre_early;
   assign stat.far       = far;
   assign stat.l_zero    = (l_ff == 64'd0);
   assign stat.norm_done = !hi_nz && top_bit;
   assign stat.cls       = cls;
   assign stat.dbl       = dbl_ff;

   assign out_value   = ov_ff;
   assign out_written = ow_ff;
   assign out_neg     = on_ff;
   assign out_zero    = oz_ff;

endmodule

@@ rtl/vfa_ctrl.sv @@
// ---------------------------------------------------------------------------
// vfa_ctrl
// Sequencer: walks the datapath through each instruction, owns the handshakes.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module vfa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output vfa_pkg::vfa_cmd_type   cmd,
   input  vfa_pkg::vfa_stat_type  stat
);
   import vfa_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_PRE, S_ALIGN, S_SUM, S_CHKZ, S_NORM, S_FMUL, S_MFIX,
      S_M0, S_M1, S_M2, S_M3, S_M4, S_TNEG, S_DINIT, S_DSTEP, S_DFIN,
      S_RND7, S_PACK, S_FINISH
   } state_type;

   typedef enum logic [1:0] {J_DMUL, J_NT1, J_NT2, J_FIN} job_type;

   state_type  state_ff, state_in;
   job_type    job_ff, job_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [1:0] iter_ff, iter_in;
   logic       out_valid_ff, out_valid_in;
   logic       fire;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = out_valid_ff;
   assign fire      = !out_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      cnt_in       = cnt_ff;
      iter_in      = iter_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      cmd.op       = OP_IDLE;
      cmd.pair     = PAIR_AB;
      cmd.fine     = 1'b0;
      cmd.to_t     = 1'b0;
      unique case (job_ff)
         J_DMUL: cmd.pair = PAIR_AB;
         J_NT1:  begin cmd.pair = PAIR_LB7; cmd.fine = 1'b1; cmd.to_t = 1'b1; end
         J_NT2:  begin cmd.pair = PAIR_LT;  cmd.fine = 1'b1; end
         J_FIN:  begin cmd.pair = PAIR_LA7; cmd.fine = 1'b1; end
      endcase

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_PRE;
            end
         end
         S_PRE: begin
            cmd.op = OP_PRE;
            if (stat.early) begin
               state_in = S_FINISH;
            end else begin
               unique case (stat.cls)
                  CLS_ADD: state_in = S_ALIGN;
                  CLS_MUL: begin
                     job_in   = J_DMUL;
                     state_in = stat.dbl ? S_M0 : S_FMUL;
                  end
                  CLS_DIV:   state_in = S_DINIT;
                  CLS_OTHER: state_in = S_FINISH;
               endcase
            end
         end
         S_ALIGN: begin
            cmd.op   = OP_ALIGN;
            state_in = stat.far ? S_FINISH : S_SUM;
         end
         S_SUM: begin
            cmd.op   = OP_SUM;
            state_in = S_CHKZ;
         end
         S_CHKZ: begin
            cmd.op   = OP_CHKZ;
            state_in = stat.l_zero ? S_FINISH : S_NORM;
         end
         S_NORM: begin
            cmd.op = OP_NORM;
            if (stat.norm_done) state_in = S_PACK;
         end
         S_FMUL: begin
            cmd.op   = OP_FMUL;
            state_in = S_MFIX;
         end
         S_MFIX: begin
            cmd.op   = OP_MFIX;
            state_in = S_PACK;
         end
         S_M0: begin cmd.op = OP_M0; state_in = S_M1; end
         S_M1: begin cmd.op = OP_M1; state_in = S_M2; end
         S_M2: begin cmd.op = OP_M2; state_in = S_M3; end
         S_M3: begin cmd.op = OP_M3; state_in = S_M4; end
         S_M4: begin
            cmd.op = OP_M4;
            unique case (job_ff)
               J_DMUL: state_in = S_MFIX;
               J_NT1:  state_in = S_TNEG;
               J_NT2: begin
                  iter_in  = iter_ff + 2'd1;
                  job_in   = (iter_ff == 2'd2) ? J_FIN : J_NT1;
                  state_in = S_M0;
               end
               J_FIN:  state_in = S_RND7;
            endcase
         end
         S_TNEG: begin
            cmd.op   = OP_TNEG;
            job_in   = J_NT2;
            state_in = S_M0;
         end
         S_DINIT: begin
            cmd.op   = OP_DINIT;
            cnt_in   = 6'd0;
            state_in = S_DSTEP;
         end
         S_DSTEP: begin
            cmd.op = OP_DSTEP;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) state_in = S_DFIN;
         end
         S_DFIN: begin
            cmd.op = OP_DFIN;
            if (stat.dbl) begin
               job_in   = J_NT1;
               iter_in  = 2'd0;
               state_in = S_M0;
            end else begin
               state_in = S_CHKZ;
            end
         end
         S_RND7: begin
            cmd.op   = OP_RND7;
            state_in = S_CHKZ;
         end
         S_PACK: begin
            cmd.op   = OP_PACK;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (fire) begin
               cmd.op       = OP_FINISH;
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         job_ff       <= J_DMUL;
         cnt_ff       <= 6'd0;
         iter_ff      <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         job_ff       <= job_in;
         cnt_ff       <= cnt_in;
         iter_ff      <= iter_in;
         out_valid_ff <= out_valid_in;
      end
   end

   `VFA_ASSERT_NXT(a_accept_to_pre, clock, reset, req_valid && req_ready, state_ff == S_PRE)
   `VFA_ASSERT_NXT(a_div_64_steps, clock, reset, state_ff == S_DSTEP && cnt_ff == 6'd63, state_ff == S_DFIN)
   `VFA_ASSERT_IMP(a_rsp_from_finish, clock, reset, $rose(out_valid_ff), $past(state_ff) == S_FINISH)
   `VFA_ASSERT_IMP(a_three_newton, clock, reset, state_ff == S_RND7, iter_ff == 2'd3)

endmodule

@@ rtl/vax_float_alu_core.sv @@
// ---------------------------------------------------------------------------
// vax_float_alu_core
// VAX F/D floating add, subtract, multiply, divide and compare unit.
// ---------------------------------------------------------------------------
// One instruction word in, one result word out. Compare, zero and reserved
// operands finish early, as do far-apart adds; a D divide takes longest. The
// long paths are the restoring divider that forms the F quotient and the D
// reciprocal seed, the shared 32x32 multiplier that builds each 64-bit scaled
// product from four partial products and a rounding step (D multiply one
// product, D divide seven), and the one-bit-per-cycle normalizer, which has
// most to do after a cancelling add. The unit works on one instruction at a
// time; a new word is taken while the previous result still waits in the
// output register.
// ---------------------------------------------------------------------------
module vax_float_alu_core (
   input  logic       clock,
   input  logic       reset,
   vfa_req_if.sink    req_if,
   vfa_rsp_if.source  rsp_if
);
   import vfa_pkg::*;

   vfa_cmd_type  cmd;    // controller -> datapath step
   vfa_stat_type stat;   // datapath -> controller branch conditions

   vfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // operands captured on accept; F words drop their upper 32 bits there
   vfa_datapath u_datapath (
      .clock       (clock),
      .in_mode     (req_if.mode),
      .in_dbl      (req_if.is_double),
      .in_a        (req_if.operand_a),
      .in_b        (req_if.operand_b),
      .cmd         (cmd),
      .stat        (stat),
      .out_value   (rsp_if.result_value),
      .out_written (rsp_if.result_written),
      .out_neg     (rsp_if.flag_negative),
      .out_zero    (rsp_if.flag_zero)
   );

endmodule
